/* hdl/yaz0_pkg.sv */
// ---------------------------------------------------------------------------
// yaz0_pkg
// Shared types, constants and decoder phase codes for the stream decompressor.
// ---------------------------------------------------------------------------
package yaz0_pkg;

   localparam int WINDOW_DEPTH_DEF = 4096;
   localparam int OUT_LANES_DEF    = 8;
   localparam int TRAIL_LIMIT_DEF  = 32;
   localparam int LANES            = 8;

   localparam logic [7:0] LONG_BIAS = 8'h12;
   localparam logic [7:0] FLAG_TOP  = 8'h80;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MAGIC   = 2'd1;
   localparam logic [1:0] ST_OVERRUN = 2'd2;
   localparam logic [1:0] ST_TRAIL   = 2'd3;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_NORMAL = 2'd1,
      PH_SHORT  = 2'd2,
      PH_LONG   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_COPY = 2'd1,
      FSM_SEND = 2'd2
   } fsm_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       new_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte_0;
      logic [7:0] out_byte_1;
      logic [7:0] out_byte_2;
      logic [7:0] out_byte_3;
      logic [7:0] out_byte_4;
      logic [7:0] out_byte_5;
      logic [7:0] out_byte_6;
      logic [7:0] out_byte_7;
      logic [3:0] lane_count;
      logic       run_last;
      logic [1:0] status;
      logic       finished;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic take;      // decode the byte in req payload
      logic copy_step; // move one byte through the window
      logic flush;     // load output register with collected lanes
      logic last;      // flush is final one of this word
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic copy_start;
      logic copy_more;  // copy bytes still pending after this step
      logic lanes_full; // lane buffer will be full after this step
   } sts_type;

endpackage

/* hdl/yaz0_stream_decompressor.sv */
// ---------------------------------------------------------------------------
// yaz0_stream_decompressor
// Byte-in Yaz0 decoder: header check, flag groups, 4 KiB window, 8-lane words.
// ---------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  req_     in         req_valid/req_stall yaz0_pkg::req_type
//  rsp_     out        rsp_valid/rsp_stall yaz0_pkg::rsp_type
//  csr_     in         csr_wr_en           size_limit, 32 bits
// Header, flag and literal bytes: one per cycle unless rsp_stall holds a word or a copy runs.
// A back reference of n bytes: take, n copy steps through the window (a flush per full lane group), a final flush.
// No clearing pass after reset; reset is synchronous and active high.
// An output word held by rsp_stall freezes the decoder and stalls req_.
// ---------------------------------------------------------------------------
module yaz0_stream_decompressor #(
   parameter int WINDOW_DEPTH = yaz0_pkg::WINDOW_DEPTH_DEF,
   parameter int TRAIL_LIMIT  = yaz0_pkg::TRAIL_LIMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  yaz0_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output yaz0_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   logic [31:0] size_limit_ff;
   yaz0_pkg::cmd_type cmd;
   yaz0_pkg::sts_type sts;
   logic out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_limit_ff <= 32'd0;
      end else if (csr_wr_en) begin
         size_limit_ff <= csr_wr_data;
      end
   end

   yaz0_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .out_busy(out_busy), .sts(sts), .cmd(cmd)
   );

   yaz0_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH), .TRAIL_LIMIT(TRAIL_LIMIT)) u_dp (
      .clock(clock), .reset(reset), .size_limit(size_limit_ff), .req_data(req_data),
      .cmd(cmd), .sts(sts), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(rsp_data), .out_busy(out_busy)
   );

endmodule

/* hdl/yaz0_ctrl.sv */
// ---------------------------------------------------------------------------
// yaz0_ctrl
// Sequencer: accepts an input byte, runs copies byte by byte, flushes lane groups.
// ---------------------------------------------------------------------------
module yaz0_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             out_busy,
   input  yaz0_pkg::sts_type sts,
   output yaz0_pkg::cmd_type cmd
);

   yaz0_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= yaz0_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         yaz0_pkg::FSM_IDLE: begin
            if (req_valid && !out_busy) begin
               state_in = sts.copy_start ? yaz0_pkg::FSM_COPY : yaz0_pkg::FSM_IDLE;
            end
         end
         yaz0_pkg::FSM_COPY: begin
            if (!out_busy && !sts.copy_more) begin
               state_in = yaz0_pkg::FSM_SEND;
            end
         end
         yaz0_pkg::FSM_SEND: begin
            if (!out_busy) begin
               state_in = yaz0_pkg::FSM_IDLE;
            end
         end
         default: state_in = yaz0_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         yaz0_pkg::FSM_IDLE: begin
            req_stall = out_busy;
            if (req_valid && !out_busy) begin
               cmd.take = 1'b1;
               if (!sts.copy_start) begin
                  cmd.flush = 1'b1;
                  cmd.last  = 1'b1;
               end
            end
         end
         yaz0_pkg::FSM_COPY: begin
            if (!out_busy) begin
               cmd.copy_step = 1'b1;
               cmd.flush     = sts.lanes_full && sts.copy_more;
            end
         end
         yaz0_pkg::FSM_SEND: begin
            if (!out_busy) begin
               cmd.flush = 1'b1;
               cmd.last  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> state_ff == yaz0_pkg::FSM_IDLE)
      else $error("take outside idle");
   a_no_flush_busy: assert property (@(posedge clock) disable iff (reset)
      out_busy |-> !cmd.flush && !cmd.take && !cmd.copy_step)
      else $error("command while output busy");
   a_copy_to_send: assert property (@(posedge clock) disable iff (reset)
      (state_ff == yaz0_pkg::FSM_COPY && cmd.copy_step && !sts.copy_more)
      |=> state_ff == yaz0_pkg::FSM_SEND)
      else $error("copy did not end in send");

endmodule

/* hdl/yaz0_datapath.sv */
// ---------------------------------------------------------------------------
// yaz0_datapath
// Header parse, flag decode, history window, lane collection, output register.
// ---------------------------------------------------------------------------
module yaz0_datapath #(
   parameter int WINDOW_DEPTH = yaz0_pkg::WINDOW_DEPTH_DEF,
   parameter int TRAIL_LIMIT  = yaz0_pkg::TRAIL_LIMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       size_limit,
   input  yaz0_pkg::req_type req_data,
   input  yaz0_pkg::cmd_type cmd,
   output yaz0_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output yaz0_pkg::rsp_type rsp_data,
   output logic              out_busy
);

   localparam int AW = $clog2(WINDOW_DEPTH);

   yaz0_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  hleft_ff, hleft_in;
   logic [31:0] remain_ff, remain_in;
   logic [7:0]  flag_ff, flag_in, mask_ff, mask_in, high_ff, high_in;
   logic [AW-1:0] dist_ff, dist_in, ptr_ff, ptr_in;
   logic [5:0]  trail_ff, trail_in;
   logic [1:0]  err_ff, err_in;
   logic [8:0]  cnt_ff, cnt_in;
   logic [7:0]  win [WINDOW_DEPTH];
   logic [7:0]  lane_ff [yaz0_pkg::LANES];
   logic [3:0]  nl_ff, nl_in;
   logic        rv_ff;
   yaz0_pkg::rsp_type rsp_ff;

   // decode of the incoming byte (after restart, gated by the sticky error)
   yaz0_pkg::phase_type ph_c;
   logic [4:0]  hl_c, pos;
   logic [31:0] rem_c;
   logic [7:0]  b;
   logic [7:0]  magic_c;
   logic [15:0] pair;
   logic [8:0]  copy_n;
   logic        do_copy, lit;
   logic [7:0]  lit_byte;
   logic [7:0]  rd_byte;

   assign b = req_data.in_byte;
   assign ph_c  = req_data.new_stream ? yaz0_pkg::PH_HEADER : phase_ff;
   assign hl_c  = req_data.new_stream ? 5'd16 : hleft_ff;
   assign rem_c = req_data.new_stream ? 32'd0 : remain_ff;
   assign pos   = hl_c - 5'd1;
   assign pair  = {high_ff, b};

   always_comb begin
      case (pos[1:0])
         2'd3:    magic_c = 8'h59;
         2'd2:    magic_c = 8'h61;
         2'd1:    magic_c = 8'h7a;
         default: magic_c = 8'h30;
      endcase
   end

   always_comb begin
      logic [1:0] e;
      logic [5:0] t;
      logic [7:0] fm, fb;
      logic [31:0] rr;
      logic [8:0]  n;
      e = req_data.new_stream ? yaz0_pkg::ST_OK : err_ff;
      t = req_data.new_stream ? 6'd0 : trail_ff;
      fm = req_data.new_stream ? 8'd0 : mask_ff;
      fb = req_data.new_stream ? 8'd0 : flag_ff;
      phase_in = ph_c; hleft_in = hl_c; remain_in = rem_c;
      flag_in = fb; mask_in = fm; high_in = req_data.new_stream ? 8'd0 : high_ff;
      dist_in = req_data.new_stream ? '0 : dist_ff;
      trail_in = t; err_in = e;
      do_copy = 1'b0; lit = 1'b0; copy_n = 9'd0; n = 9'd0; rr = 32'd0;
      if (e == yaz0_pkg::ST_OK) begin
         case (ph_c)
            yaz0_pkg::PH_HEADER: begin
               hleft_in = pos;
               if (pos >= 5'd12 && b != magic_c) begin
                  err_in = yaz0_pkg::ST_MAGIC;
               end else begin
                  rr = rem_c;
                  if (pos >= 5'd8 && pos <= 5'd11) begin
                     rr = rem_c | ({24'd0, b} << {pos[1:0], 3'd0});
                  end
                  remain_in = rr;
                  if (pos == 5'd0) begin
                     if (size_limit != 32'd0 && size_limit < rr) remain_in = size_limit;
                     phase_in = yaz0_pkg::PH_NORMAL;
                  end
               end
            end
            yaz0_pkg::PH_SHORT, yaz0_pkg::PH_LONG: begin
               if (ph_c == yaz0_pkg::PH_SHORT) begin
                  dist_in = pair[AW-1:0] + AW'(1);
                  n = {5'd0, pair[15:12]} + 9'd2;
               end else begin
                  n = {1'b0, b} + {1'b0, yaz0_pkg::LONG_BIAS};
               end
               if (ph_c == yaz0_pkg::PH_SHORT && pair[15:12] == 4'd0) begin
                  phase_in = yaz0_pkg::PH_LONG;
               end else if ({23'd0, n} > rem_c && size_limit == 32'd0) begin
                  err_in = yaz0_pkg::ST_OVERRUN;
               end else begin
                  copy_n = ({23'd0, n} > rem_c) ? rem_c[8:0] : n;
                  remain_in = rem_c - {23'd0, copy_n};
                  do_copy = copy_n != 9'd0;
                  phase_in = yaz0_pkg::PH_NORMAL;
               end
            end
            default: begin
               if (rem_c == 32'd0) begin
                  if (t != 6'd63) trail_in = t + 6'd1;
                  if (size_limit == 32'd0 && trail_in > 6'(TRAIL_LIMIT))
                     err_in = yaz0_pkg::ST_TRAIL;
               end else if (fm == 8'd0) begin
                  flag_in = b; mask_in = yaz0_pkg::FLAG_TOP;
               end else begin
                  if ((fb & fm) != 8'd0) begin
                     lit = 1'b1;
                     remain_in = rem_c - 32'd1;
                  end else begin
                     high_in = b;
                     phase_in = yaz0_pkg::PH_SHORT;
                  end
                  mask_in = fm >> 1;
               end
            end
         endcase
      end
   end

   assign lit_byte = b;
   assign sts.copy_start = do_copy;
   assign sts.copy_more  = cnt_ff > 9'd1;
   assign sts.lanes_full = nl_ff == 4'd7;

   // window read is registered ahead of use; copy distance >= 1 keeps data ordering
   logic [AW-1:0] rd_addr;
   logic [7:0]    wr_byte;
   logic          wr_en;
   logic          fwd;
   logic [7:0]    last_wr_ff;
   assign rd_addr = ptr_in - (cmd.take ? dist_in : dist_ff);
   always_ff @(posedge clock) begin
      rd_byte <= win[rd_addr];
      if (wr_en) win[ptr_ff] <= wr_byte;
   end
   always_ff @(posedge clock) begin
      last_wr_ff <= wr_byte;
      fwd <= wr_en && (rd_addr == ptr_ff);
   end

   always_comb begin
      wr_en = 1'b0; wr_byte = lit_byte;
      ptr_in = (cmd.take && req_data.new_stream) ? '0 : ptr_ff;
      cnt_in = cnt_ff; nl_in = nl_ff;
      if (cmd.take) begin
         cnt_in = copy_n;
         if (lit) begin
            wr_en = 1'b1; ptr_in = ptr_in + AW'(1);
         end
      end else if (cmd.copy_step) begin
         wr_en = 1'b1; wr_byte = fwd ? last_wr_ff : rd_byte;
         ptr_in = ptr_ff + AW'(1);
         cnt_in = cnt_ff - 9'd1;
      end
      if (wr_en) nl_in = nl_ff + 4'd1;
      if (cmd.flush) nl_in = 4'd0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) lane_ff[nl_ff[2:0]] <= wr_byte;
   end

   // output register
   logic [7:0] lv [yaz0_pkg::LANES];
   logic [3:0] nsend;
   always_comb begin
      nsend = wr_en ? nl_ff + 4'd1 : nl_ff;
      for (int i = 0; i < yaz0_pkg::LANES; i++) begin
         if (4'(i) >= nsend) lv[i] = 8'd0;
         else if (wr_en && 4'(i) == nl_ff) lv[i] = wr_byte;
         else lv[i] = lane_ff[i];
      end
   end

   assign out_busy = rv_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         phase_ff <= yaz0_pkg::PH_HEADER; hleft_ff <= 5'd16; remain_ff <= '0;
         flag_ff <= '0; mask_ff <= '0; high_ff <= '0; dist_ff <= '0; ptr_ff <= '0;
         trail_ff <= '0; err_ff <= '0; cnt_ff <= '0; nl_ff <= '0;
      end else begin
         if (cmd.flush) rv_ff <= 1'b1;
         else if (!rsp_stall) rv_ff <= 1'b0;
         if (cmd.take) begin
            phase_ff <= phase_in; hleft_ff <= hleft_in; remain_ff <= remain_in;
            flag_ff <= flag_in; mask_ff <= mask_in; high_ff <= high_in;
            dist_ff <= dist_in; trail_ff <= trail_in; err_ff <= err_in;
         end
         ptr_ff <= ptr_in; cnt_ff <= cnt_in; nl_ff <= nl_in;
      end
   end

   logic [1:0] st_now;
   logic       fin_now;
   assign st_now  = cmd.take ? err_in : err_ff;
   assign fin_now = cmd.take ? (phase_in == yaz0_pkg::PH_NORMAL && remain_in == 32'd0)
                             : (phase_ff == yaz0_pkg::PH_NORMAL && remain_ff == 32'd0);

   always_ff @(posedge clock) begin
      if (cmd.flush) begin
         rsp_ff <= {lv[0], lv[1], lv[2], lv[3], lv[4], lv[5], lv[6], lv[7],
                    nsend, cmd.last, st_now, fin_now};
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   a_lane_bound: assert property (@(posedge clock) disable iff (reset)
      nl_ff <= 4'd8) else $error("lane overflow");
   a_flush_hold: assert property (@(posedge clock) disable iff (reset)
      out_busy |=> $stable(rsp_ff)) else $error("output changed while stalled");
   a_copy_count: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_step |-> cnt_ff != 9'd0) else $error("copy step with no bytes");

endmodule

/* verif/tb_yaz0_stream_decompressor.sv */
// ---------------------------------------------------------------------------
// tb_yaz0_stream_decompressor
// Self-checking bench: drives compressed streams byte by byte, predicts the
// decoded output words and compares every field of every response word.
// ---------------------------------------------------------------------------
module tb_yaz0_stream_decompressor;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   yaz0_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   yaz0_pkg::rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   yaz0_stream_decompressor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [31:0] limit_reg;
   yaz0_pkg::phase_type dec_phase;
   logic [4:0]  hdr_left;
   logic [31:0] remaining;
   logic [7:0]  flags, flag_mask, ref_high;
   logic [12:0] distance;
   logic [7:0]  window [4096];
   logic [11:0] wptr;
   logic [5:0]  trail_cnt;
   logic [1:0]  err;
   logic [7:0]  decoded [$];
   yaz0_pkg::rsp_type expected_words [$];

   int cycles = 0;
   int mismatches = 0;
   bit failed = 0;
   bit quiet = 0;

   function automatic void restart_decoder();
      dec_phase = yaz0_pkg::PH_HEADER; hdr_left = 5'd16; remaining = '0; flags = '0;
      flag_mask = '0; ref_high = '0; distance = '0; wptr = '0; trail_cnt = '0;
      err = yaz0_pkg::ST_OK;
   endfunction

   function automatic void emit(logic [7:0] b);
      window[wptr] = b;
      wptr = wptr + 12'd1;
      decoded.push_back(b);
   endfunction

   function automatic void copy_back(int n);
      if (n > remaining) begin
         if (limit_reg == 0) begin
            err = yaz0_pkg::ST_OVERRUN;
            return;
         end
         n = remaining;
      end
      remaining = remaining - n;
      for (int i = 0; i < n; i++) emit(window[wptr - distance[11:0]]);
      dec_phase = yaz0_pkg::PH_NORMAL;
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      logic [4:0]  pos;
      logic [15:0] pair;
      if (dec_phase == yaz0_pkg::PH_HEADER) begin
         pos = hdr_left - 5'd1;
         hdr_left = pos;
         if (pos >= 12 && pos <= 15) begin
            if (b != 8'("Yaz0" >> ((pos - 5'd12) * 8))) begin
               err = yaz0_pkg::ST_MAGIC;
               return;
            end
         end else if (pos >= 8 && pos <= 11)
            remaining = remaining | (32'(b) << ((pos - 8) * 8));
         if (pos == 0) begin
            if (limit_reg > 0 && limit_reg < remaining) remaining = limit_reg;
            dec_phase = yaz0_pkg::PH_NORMAL;
         end
      end else if (dec_phase == yaz0_pkg::PH_SHORT) begin
         pair = {ref_high, b};
         distance = {1'b0, pair[11:0]} + 13'd1;
         if (pair[15:12] == 0) dec_phase = yaz0_pkg::PH_LONG;
         else copy_back(int'(pair[15:12]) + 2);
      end else if (dec_phase == yaz0_pkg::PH_LONG) begin
         copy_back(int'(b) + int'(yaz0_pkg::LONG_BIAS));
      end else if (remaining == 0) begin
         if (trail_cnt < 63) trail_cnt++;
         if (limit_reg == 0 && trail_cnt > 32) err = yaz0_pkg::ST_TRAIL;
      end else if (flag_mask == 0) begin
         flags = b;
         flag_mask = yaz0_pkg::FLAG_TOP;
      end else begin
         if ((flags & flag_mask) != 0) begin
            emit(b);
            remaining--;
         end else begin
            ref_high = b;
            dec_phase = yaz0_pkg::PH_SHORT;
         end
         flag_mask = flag_mask >> 1;
      end
   endfunction

   function automatic void predict_words(yaz0_pkg::req_type r);
      int n, words;
      yaz0_pkg::rsp_type w;
      if (r.new_stream) restart_decoder();
      decoded.delete();
      if (err == yaz0_pkg::ST_OK) decode_byte(r.in_byte);
      n = decoded.size();
      words = (n == 0) ? 1 : (n + 7) / 8;
      for (int k = 0; k < words; k++) begin
         w = '0;
         for (int j = 0; j < 8 && k * 8 + j < n; j++) begin
            w.lane_count++;
            case (j)
               0: w.out_byte_0 = decoded[k * 8 + j];
               1: w.out_byte_1 = decoded[k * 8 + j];
               2: w.out_byte_2 = decoded[k * 8 + j];
               3: w.out_byte_3 = decoded[k * 8 + j];
               4: w.out_byte_4 = decoded[k * 8 + j];
               5: w.out_byte_5 = decoded[k * 8 + j];
               6: w.out_byte_6 = decoded[k * 8 + j];
               default: w.out_byte_7 = decoded[k * 8 + j];
            endcase
         end
         w.run_last = (k == words - 1);
         w.status = err;
         w.finished = (dec_phase == yaz0_pkg::PH_NORMAL && remaining == 0);
         expected_words.push_back(w);
      end
   endfunction

   // response checker and sink idling
   int sink_gap = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            failed = 1;
            if (mismatches < 10) $display("unexpected word %h", rsp_data);
            mismatches++;
         end else begin
            if (rsp_data !== expected_words[0]) begin
               failed = 1;
               if (mismatches < 10)
                  $display("mismatch exp %h got %h", expected_words[0], rsp_data);
               mismatches++;
            end
            void'(expected_words.pop_front());
         end
      end
      if (quiet || sink_gap == 0) begin
         rsp_stall <= 1'b0;
         if (!quiet && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 8);
      end else begin
         rsp_stall <= 1'b1;
         sink_gap--;
      end
   end

   task automatic send_word(yaz0_pkg::req_type r);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict_words(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_limit(logic [31:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_reg = v;
   endtask

   function automatic yaz0_pkg::req_type mk(logic [7:0] b, bit ns);
      yaz0_pkg::req_type r;
      r.in_byte = b;
      r.new_stream = ns;
      return r;
   endfunction

   // stream with a valid header: literals first so back references stay in written data
   task automatic send_stream(int total_len, int groups);
      int produced;
      logic [7:0] f;
      send_word(mk("Y", 1)); send_word(mk("a", 0));
      send_word(mk("z", 0)); send_word(mk("0", 0));
      for (int i = 3; i >= 0; i--) send_word(mk(8'(total_len >> (i * 8)), 0));
      for (int i = 0; i < 8; i++) send_word(mk(8'($urandom), 0));
      produced = 0;
      for (int g = 0; g < groups; g++) begin
         f = (produced < 4) ? 8'hFF : 8'($urandom);
         send_word(mk(f, 0));
         for (int k = 7; k >= 0; k--) begin
            if (f[k] || produced == 0) begin
               send_word(mk(8'($urandom), 0));
               produced++;
            end else begin
               int d, n;
               d = $urandom_range(0, (produced > 4096 ? 4096 : produced) - 1);
               if ($urandom_range(0, 3) == 0) begin
                  send_word(mk(8'(d >> 8), 0));
                  send_word(mk(8'(d), 0));
                  n = $urandom_range(0, 255);
                  send_word(mk(8'(n), 0));
                  produced += n + 18;
               end else begin
                  n = $urandom_range(1, 15);
                  send_word(mk(8'((n << 4) | (d >> 8)), 0));
                  send_word(mk(8'(d), 0));
                  produced += n + 2;
               end
            end
         end
      end
   endtask

   typedef struct {
      logic [7:0] b;
      bit ns;
      bit chk;
      logic [1:0] st;
   } dir_row_type;

   dir_row_type dir_rows [] = '{
      '{8'h59, 1, 1, yaz0_pkg::ST_OK}, '{8'h00, 0, 1, yaz0_pkg::ST_MAGIC},
      '{8'hFF, 0, 1, yaz0_pkg::ST_MAGIC},
      '{8'h59, 1, 0, yaz0_pkg::ST_OK}, '{8'h61, 0, 0, yaz0_pkg::ST_OK},
      '{8'h7A, 0, 0, yaz0_pkg::ST_OK}, '{8'h30, 0, 0, yaz0_pkg::ST_OK},
      '{8'h00, 0, 0, yaz0_pkg::ST_OK}, '{8'h00, 0, 0, yaz0_pkg::ST_OK},
      '{8'h00, 0, 0, yaz0_pkg::ST_OK}, '{8'h14, 0, 0, yaz0_pkg::ST_OK},
      '{8'hFF, 0, 0, yaz0_pkg::ST_OK}, '{8'h00, 0, 0, yaz0_pkg::ST_OK},
      '{8'hAA, 0, 0, yaz0_pkg::ST_OK}, '{8'h55, 0, 0, yaz0_pkg::ST_OK},
      '{8'h01, 0, 0, yaz0_pkg::ST_OK}, '{8'h02, 0, 0, yaz0_pkg::ST_OK},
      '{8'h04, 0, 0, yaz0_pkg::ST_OK}, '{8'h80, 0, 0, yaz0_pkg::ST_OK},
      '{8'hC0, 0, 0, yaz0_pkg::ST_OK}, '{8'hFF, 0, 0, yaz0_pkg::ST_OK},
      '{8'h00, 0, 0, yaz0_pkg::ST_OK}, '{8'hF0, 0, 0, yaz0_pkg::ST_OK},
      '{8'h00, 0, 0, yaz0_pkg::ST_OK}, '{8'h00, 0, 0, yaz0_pkg::ST_OK},
      '{8'h00, 0, 0, yaz0_pkg::ST_OK}, '{8'h10, 0, 1, yaz0_pkg::ST_OVERRUN}
   };

   initial begin
      restart_decoder();
      limit_reg = '0;
      for (int i = 0; i < 4096; i++) window[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: bad magic, then header of size 20, flag with two literals,
      // short and long references, overrun of a long copy
      foreach (dir_rows[i]) begin
         send_word(mk(dir_rows[i].b, dir_rows[i].ns));
         if (dir_rows[i].chk && expected_words[$].status != dir_rows[i].st) begin
            failed = 1;
            $display("directed row %0d status %0d", i, expected_words[$].status);
         end
      end
      // zero size header then trailing data past the limit
      send_stream(0, 0);
      for (int i = 0; i < 33; i++) send_word(mk(8'($urandom), 0));
      set_limit(32'd25);
      send_stream(600, 2);
      set_limit(32'd0);
      send_stream($urandom_range(10, 400), 2);
      drain();
      quiet = 1;
      send_stream(100, 1);
      drain();
      if (!failed)
         $display("yaz0_stream_decompressor regression: pass");
      else
         $display("yaz0_stream_decompressor regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("yaz0_stream_decompressor regression: fail");
         $finish;
      end
   end

endmodule
